[sv/ctl_pkg.sv]
package ctl_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } ctl_in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [16:0] token_length;
    logic [1:0]  status_code;
    logic        last_of_text;
  } ctl_out_t;

  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_HASH   = 4'd1,
    M_PREP   = 4'd2,
    M_STR    = 4'd3,
    M_CHR    = 4'd4,
    M_LT     = 4'd5,
    M_GT     = 4'd6,
    M_EQ     = 4'd7,
    M_BANG   = 4'd8,
    M_WORD   = 4'd9,
    M_NUM    = 4'd10,
    M_NUMDOT = 4'd11,
    M_FRAC   = 4'd12
  } mode_e;

  localparam logic [2:0] K_KEYWORD = 3'd0;
  localparam logic [2:0] K_PREP    = 3'd1;
  localparam logic [2:0] K_STRING  = 3'd2;
  localparam logic [2:0] K_NUMBER  = 3'd3;
  localparam logic [2:0] K_SYMBOL  = 3'd4;
  localparam logic [2:0] K_IDENT   = 3'd5;

  localparam logic [1:0] ST_TOKEN = 2'd0;
  localparam logic [1:0] ST_ERROR = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;
  localparam logic [1:0] ST_END   = 2'd3;

  localparam int unsigned NumKw = 23;
  localparam logic [63:0] KwTab [NumKw] = '{
    64'h696e74, 64'h766f6964, 64'h666c6f6174, 64'h646f75626c65, 64'h63686172,
    64'h626f6f6c, 64'h737472696e67, 64'h72657475726e, 64'h6966, 64'h656c7365,
    64'h7768696c65, 64'h666f72, 64'h737769746368, 64'h63617365, 64'h627265616b,
    64'h636f6e74696e7565, 64'h636f7574, 64'h63696e, 64'h656e756d,
    64'h737472756374, 64'h636f6e7374, 64'h74727565, 64'h66616c7365
  };

  function automatic logic is_keyword(input logic [63:0] w);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumKw; i++) begin
      if (KwTab[i] == w) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

[sv/ctl_fifo.sv]
module ctl_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_cnt_i,
  input  ctl_pkg::ctl_out_t push_data_i [3],
  output logic [2:0]      free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ctl_pkg::ctl_out_t out_data_o
);
  import ctl_pkg::*;

  localparam int unsigned Depth = 8;

  ctl_out_t    mem_q [Depth];
  logic [2:0]  wr_q, rd_q;
  logic [3:0]  cnt_q;
  logic        pop;
  logic [3:0]  room;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != 4'd0;
  assign out_data_o  = mem_q[rd_q];
  assign room        = 4'(Depth) - cnt_q;
  // room for one full burst means free
  assign free_o      = (room >= 4'd6) ? 3'd6 : room[2:0];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_cnt_i) mem_q[wr_q + 3'(i)] <= push_data_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + 3'(push_cnt_i);
      if (pop) rd_q <= rd_q + 3'd1;
      cnt_q <= cnt_q + 4'(push_cnt_i) - 4'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(Depth)) else $error("fifo overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 4'd0) else $error("pop when empty");
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q + 4'(push_cnt_i)) <= 4'(Depth) + 4'(pop)) else $error("push without room");
`endif
endmodule

[sv/c_token_lexer.sv]
// output: a token is written into the output queue when the byte that ends it is accepted
// throughput: one byte or end-of-text transaction per cycle; each may give up to
//   three results, buffered in an eight-entry queue that holds off input when low
// reset: asynchronous active low, lexer idle at offset zero, queue empty
module c_token_lexer #(
  parameter int unsigned MAX_TEXT_LEN = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ctl_pkg::ctl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ctl_pkg::ctl_out_t out_data_o
);
  import ctl_pkg::*;

  localparam int unsigned PW = $clog2(MAX_TEXT_LEN + 1);

  mode_e        mode_q, mode_d;
  logic [63:0]  word_q, word_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] beg_q, beg_d;
  logic         skip_q, skip_d;

  ctl_out_t    res [3];
  logic [1:0]  n;
  logic [2:0]  free;
  logic        acc;
  logic [7:0]  c;
  logic [PW-1:0] p, b;
  logic        sp, dg, al, sym;

  assign in_ready_o = free >= 3'd3;
  assign acc = in_valid_i && in_ready_o;
  assign c = in_data_i.text_byte;
  assign p = pos_q;
  assign b = beg_q;
  assign sp = c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  assign dg = c >= "0" && c <= "9";
  assign al = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  always_comb begin
    case (c)
      "(", ")", "{", "}", ";", ",", "=", "+", "*", "/", "-", "<", ">", "%",
      ".", "[", "]", ":": sym = 1'b1;
      default: sym = 1'b0;
    endcase
  end

  always_comb begin
    logic [PW-1:0] lenv;
    logic          restart;
    mode_d = mode_q;
    word_d = word_q;
    pos_d  = pos_q;
    beg_d  = beg_q;
    skip_d = skip_q;
    n      = 2'd0;
    restart = 1'b0;
    lenv   = p - b;
    for (int i = 0; i < 3; i++) res[i] = '0;

    if (in_data_i.end_of_text) begin
      if (!skip_q) begin
        case (mode_q)
          M_HASH, M_STR, M_CHR, M_BANG: begin
            res[0] = '{K_KEYWORD, 16'(b), 17'd0, ST_ERROR, 1'b0}; n = 2'd1;
          end
          M_PREP: begin res[0] = '{K_PREP, 16'(b), 17'(lenv), ST_TOKEN, 1'b0}; n = 2'd1; end
          M_LT, M_GT, M_EQ: begin
            res[0] = '{K_SYMBOL, 16'(b), 17'd1, ST_TOKEN, 1'b0}; n = 2'd1;
          end
          M_WORD: begin
            res[0] = '{((lenv <= PW'(8)) && is_keyword(word_q)) ? K_KEYWORD : K_IDENT,
                       16'(b), 17'(lenv), ST_TOKEN, 1'b0};
            n = 2'd1;
          end
          M_NUM, M_FRAC: begin
            res[0] = '{K_NUMBER, 16'(b), 17'(lenv), ST_TOKEN, 1'b0}; n = 2'd1;
          end
          M_NUMDOT: begin
            res[0] = '{K_NUMBER, 16'(b), 17'(lenv - PW'(1)), ST_TOKEN, 1'b0};
            res[1] = '{K_SYMBOL, 16'(p - PW'(1)), 17'd1, ST_TOKEN, 1'b0};
            n = 2'd2;
          end
          default: ;
        endcase
      end
      res[n] = '{K_KEYWORD, 16'd0, 17'd0, ST_END, 1'b1};
      n = n + 2'd1;
      mode_d = M_IDLE; word_d = '0; pos_d = '0; beg_d = '0; skip_d = 1'b0;
    end else if (!skip_q) begin
      if (pos_q >= PW'(MAX_TEXT_LEN)) begin
        res[0] = '{K_KEYWORD, 16'd0, 17'd0, ST_LONG, 1'b0}; n = 2'd1;
        skip_d = 1'b1; mode_d = M_IDLE;
      end else begin
        pos_d = pos_q + PW'(1);
        case (mode_q)
          M_HASH: if (al) mode_d = M_PREP;
                  else begin
                    res[0] = '{K_KEYWORD, 16'(b), 17'd0, ST_ERROR, 1'b0}; n = 2'd1;
                    skip_d = 1'b1; mode_d = M_IDLE;
                  end
          M_PREP: if (c == 8'h0a) begin
                    res[0] = '{K_PREP, 16'(b), 17'(lenv), ST_TOKEN, 1'b0}; n = 2'd1;
                    mode_d = M_IDLE;
                  end
          M_STR: if (c == "\"") begin
                   res[0] = '{K_STRING, 16'(b), 17'(lenv + PW'(1)), ST_TOKEN, 1'b0};
                   n = 2'd1; mode_d = M_IDLE;
                 end
          M_CHR: if (c == "'") begin
                   res[0] = '{K_IDENT, 16'(b), 17'(lenv + PW'(1)), ST_TOKEN, 1'b0};
                   n = 2'd1; mode_d = M_IDLE;
                 end
          M_LT, M_GT, M_EQ: begin
            if ((mode_q == M_LT && (c == "<" || c == "=")) ||
                (mode_q == M_GT && (c == ">" || c == "=")) ||
                (mode_q == M_EQ && c == "=")) begin
              res[0] = '{K_SYMBOL, 16'(b), 17'd2, ST_TOKEN, 1'b0}; n = 2'd1;
              mode_d = M_IDLE;
            end else begin
              res[0] = '{K_SYMBOL, 16'(b), 17'd1, ST_TOKEN, 1'b0}; n = 2'd1;
              restart = 1'b1;
            end
          end
          M_BANG: begin
            if (c == "=") begin
              res[0] = '{K_SYMBOL, 16'(b), 17'd2, ST_TOKEN, 1'b0};
            end else begin
              res[0] = '{K_KEYWORD, 16'(b), 17'd0, ST_ERROR, 1'b0};
              skip_d = 1'b1;
            end
            n = 2'd1; mode_d = M_IDLE;
          end
          M_WORD: begin
            if (al || dg) word_d = {word_q[55:0], c};
            else begin
              res[0] = '{((lenv <= PW'(8)) && is_keyword(word_q)) ? K_KEYWORD : K_IDENT,
                         16'(b), 17'(lenv), ST_TOKEN, 1'b0};
              n = 2'd1; restart = 1'b1;
            end
          end
          M_NUM: begin
            if (c == ".") mode_d = M_NUMDOT;
            else if (!dg) begin
              res[0] = '{K_NUMBER, 16'(b), 17'(lenv), ST_TOKEN, 1'b0};
              n = 2'd1; restart = 1'b1;
            end
          end
          M_NUMDOT: begin
            if (dg) mode_d = M_FRAC;
            else begin
              res[0] = '{K_NUMBER, 16'(b), 17'(lenv - PW'(1)), ST_TOKEN, 1'b0};
              res[1] = '{K_SYMBOL, 16'(p - PW'(1)), 17'd1, ST_TOKEN, 1'b0};
              n = 2'd2; restart = 1'b1;
            end
          end
          M_FRAC: begin
            if (!dg) begin
              res[0] = '{K_NUMBER, 16'(b), 17'(lenv), ST_TOKEN, 1'b0};
              n = 2'd1; restart = 1'b1;
            end
          end
          default: restart = 1'b1;
        endcase

        if (restart) begin
          mode_d = M_IDLE;
          beg_d  = p;
          if (!sp) begin
            if (c == "#") mode_d = M_HASH;
            else if (c == "\"") mode_d = M_STR;
            else if (c == "'") mode_d = M_CHR;
            else if (c == "<") mode_d = M_LT;
            else if (c == ">") mode_d = M_GT;
            else if (c == "=") mode_d = M_EQ;
            else if (c == "!") mode_d = M_BANG;
            else if (al) begin word_d = {56'd0, c}; mode_d = M_WORD; end
            else if (dg) mode_d = M_NUM;
            else if (sym) begin
              res[n] = '{K_SYMBOL, 16'(p), 17'd1, ST_TOKEN, 1'b0};
              n = n + 2'd1;
            end else begin
              res[n] = '{K_KEYWORD, 16'(p), 17'd0, ST_ERROR, 1'b0};
              n = n + 2'd1; skip_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      word_q <= '0;
      pos_q  <= '0;
      beg_q  <= '0;
      skip_q <= 1'b0;
    end else if (acc) begin
      mode_q <= mode_d;
      word_q <= word_d;
      pos_q  <= pos_d;
      beg_q  <= beg_d;
      skip_q <= skip_d;
    end
  end

  ctl_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_cnt_i (acc ? n : 2'd0),
    .push_data_i(res),
    .free_o     (free),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

`ifndef SYNTH
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(MAX_TEXT_LEN)) else $error("position past limit");
  a_eot_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_data_i.end_of_text |=> pos_q == '0 && !skip_q && mode_q == M_IDLE)
    else $error("end of text did not restart");
  a_skip_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && skip_q && !in_data_i.end_of_text |-> n == 2'd0)
    else $error("result while skipping");
`endif
endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ctl_pkg::*;

  localparam int unsigned TextLimit = 65536;
  localparam int unsigned WatchLimit = 20000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ctl_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ctl_out_t out_data;

  c_token_lexer #(.MAX_TEXT_LEN(TextLimit)) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // lexer state as predicted
  mode_e       lex_mode;
  logic [63:0] lex_word;
  int unsigned lex_pos;
  int unsigned lex_begin;
  bit          lex_skip;

  ctl_out_t token_q[$];
  int unsigned n_errors;
  int unsigned idle_cycles;
  bit          hold_off;
  int unsigned hold_len;
  bit          stall_en;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_sym(logic [7:0] c);
    case (c)
      "(", ")", "{", "}", ";", ",", "=", "+", "*", "/", "-", "<", ">", "%", ".",
      "[", "]", ":": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit kw_match(logic [63:0] w);
    logic [63:0] kws[23];
    kws = '{64'h696e74, 64'h766f6964, 64'h666c6f6174, 64'h646f75626c65, 64'h63686172,
            64'h626f6f6c, 64'h737472696e67, 64'h72657475726e, 64'h6966, 64'h656c7365,
            64'h7768696c65, 64'h666f72, 64'h737769746368, 64'h63617365,
            64'h627265616b, 64'h636f6e74696e7565, 64'h636f7574, 64'h63696e,
            64'h656e756d, 64'h737472756374, 64'h636f6e7374, 64'h74727565,
            64'h66616c7365};
    foreach (kws[i]) if (kws[i] == w) return 1'b1;
    return 1'b0;
  endfunction

  task automatic push_token(logic [2:0] kind, int unsigned start, int unsigned len,
                            logic [1:0] st, bit last);
    ctl_out_t r;
    r.token_kind   = kind;
    r.token_start  = start[15:0];
    r.token_length = len[16:0];
    r.status_code  = st;
    r.last_of_text = last;
    token_q = {token_q, r};
  endtask

  task automatic lex_fail(int unsigned at);
    push_token(K_KEYWORD, at, 0, ST_ERROR, 1'b0);
    lex_skip = 1'b1;
    lex_mode = M_IDLE;
  endtask

  task automatic close_word(int unsigned stop);
    int unsigned len;
    len = stop - lex_begin;
    push_token((len <= 8 && kw_match(lex_word)) ? K_KEYWORD : K_IDENT, lex_begin, len,
               ST_TOKEN, 1'b0);
    lex_mode = M_IDLE;
  endtask

  task automatic lex_reset();
    lex_mode  = M_IDLE;
    lex_word  = '0;
    lex_pos   = 0;
    lex_begin = 0;
    lex_skip  = 1'b0;
  endtask

  task automatic open_token(logic [7:0] c, int unsigned p);
    lex_mode  = M_IDLE;
    lex_begin = p;
    if (is_blank(c)) return;
    if (c == "#") lex_mode = M_HASH;
    else if (c == "\"") lex_mode = M_STR;
    else if (c == "'") lex_mode = M_CHR;
    else if (c == "<") lex_mode = M_LT;
    else if (c == ">") lex_mode = M_GT;
    else if (c == "=") lex_mode = M_EQ;
    else if (c == "!") lex_mode = M_BANG;
    else if (is_letter(c)) begin
      lex_word = {56'd0, c};
      lex_mode = M_WORD;
    end else if (is_num(c)) lex_mode = M_NUM;
    else if (is_sym(c)) push_token(K_SYMBOL, p, 1, ST_TOKEN, 1'b0);
    else lex_fail(p);
  endtask

  task automatic predict_tokens(ctl_in_t it);
    logic [7:0]  c;
    int unsigned p;
    int unsigned b;
    c = it.text_byte;
    p = lex_pos;
    b = lex_begin;
    if (it.end_of_text) begin
      if (!lex_skip) begin
        case (lex_mode)
          M_HASH, M_STR, M_CHR, M_BANG: lex_fail(b);
          M_PREP: push_token(K_PREP, b, p - b, ST_TOKEN, 1'b0);
          M_LT, M_GT, M_EQ: push_token(K_SYMBOL, b, 1, ST_TOKEN, 1'b0);
          M_WORD: close_word(p);
          M_NUM, M_FRAC: push_token(K_NUMBER, b, p - b, ST_TOKEN, 1'b0);
          M_NUMDOT: begin
            push_token(K_NUMBER, b, p - 1 - b, ST_TOKEN, 1'b0);
            push_token(K_SYMBOL, p - 1, 1, ST_TOKEN, 1'b0);
          end
          default: ;
        endcase
      end
      push_token(K_KEYWORD, 0, 0, ST_END, 1'b1);
      lex_reset();
      return;
    end
    if (lex_skip) return;
    if (lex_pos >= TextLimit) begin
      push_token(K_KEYWORD, 0, 0, ST_LONG, 1'b0);
      lex_skip = 1'b1;
      lex_mode = M_IDLE;
      return;
    end
    lex_pos++;
    case (lex_mode)
      M_HASH: if (is_letter(c)) lex_mode = M_PREP; else lex_fail(b);
      M_PREP: if (c == 8'h0a) begin
        push_token(K_PREP, b, p - b, ST_TOKEN, 1'b0);
        lex_mode = M_IDLE;
      end
      M_STR: if (c == "\"") begin
        push_token(K_STRING, b, p - b + 1, ST_TOKEN, 1'b0);
        lex_mode = M_IDLE;
      end
      M_CHR: if (c == "'") begin
        push_token(K_IDENT, b, p - b + 1, ST_TOKEN, 1'b0);
        lex_mode = M_IDLE;
      end
      M_LT, M_GT, M_EQ: begin
        if ((lex_mode == M_LT && (c == "<" || c == "=")) ||
            (lex_mode == M_GT && (c == ">" || c == "=")) ||
            (lex_mode == M_EQ && c == "=")) begin
          push_token(K_SYMBOL, b, 2, ST_TOKEN, 1'b0);
          lex_mode = M_IDLE;
        end else begin
          push_token(K_SYMBOL, b, 1, ST_TOKEN, 1'b0);
          open_token(c, p);
        end
      end
      M_BANG: if (c == "=") begin
        push_token(K_SYMBOL, b, 2, ST_TOKEN, 1'b0);
        lex_mode = M_IDLE;
      end else lex_fail(b);
      M_WORD: begin
        if (is_letter(c) || is_num(c)) lex_word = {lex_word[55:0], c};
        else begin
          close_word(p);
          open_token(c, p);
        end
      end
      M_NUM: begin
        if (c == ".") lex_mode = M_NUMDOT;
        else if (!is_num(c)) begin
          push_token(K_NUMBER, b, p - b, ST_TOKEN, 1'b0);
          open_token(c, p);
        end
      end
      M_NUMDOT: begin
        if (is_num(c)) lex_mode = M_FRAC;
        else begin
          push_token(K_NUMBER, b, p - 1 - b, ST_TOKEN, 1'b0);
          push_token(K_SYMBOL, p - 1, 1, ST_TOKEN, 1'b0);
          open_token(c, p);
        end
      end
      M_FRAC: if (!is_num(c)) begin
        push_token(K_NUMBER, b, p - b, ST_TOKEN, 1'b0);
        open_token(c, p);
      end
      default: open_token(c, p);
    endcase
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // one transaction into the lexer, with a random gap first unless gaps is cleared
  task automatic send_byte(logic [7:0] c, bit eot, bit gaps = 1'b1);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    repeat (gap) @(negedge clk);
    in_data.text_byte   = c;
    in_data.end_of_text = eot;
    in_valid = 1'b1;
    predict_tokens(in_data);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_text(string s, bit gaps = 1'b1);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, gaps);
    send_byte(8'($urandom), 1'b1, gaps);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        report_mismatch("unexpected result kind", out_data.token_kind, 0);
      end else begin
        ctl_out_t w;
        w = token_q.pop_front();
        if (out_data.token_kind !== w.token_kind)
          report_mismatch("token_kind", out_data.token_kind, w.token_kind);
        if (out_data.token_start !== w.token_start)
          report_mismatch("token_start", out_data.token_start, w.token_start);
        if (out_data.token_length !== w.token_length)
          report_mismatch("token_length", out_data.token_length, w.token_length);
        if (out_data.status_code !== w.status_code)
          report_mismatch("status_code", out_data.status_code, w.status_code);
        if (out_data.last_of_text !== w.last_of_text)
          report_mismatch("last_of_text", out_data.last_of_text, w.last_of_text);
      end
    end
  end

  // receiver: random stall per result while stall_en is set, or a long hold when asked
  initial begin
    int unsigned wait_n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_off = 1'b0;
      end
      wait_n = stall_en ? $urandom_range(0, 8) : 0;
      if (wait_n != 0) begin
        out_ready = 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_text("int x = 42;");
    send_text("#include <stdio.h>\nfloat y=3.14; return");
    send_text("a<<b>>c==d!=e<=f>=g<h>i");
    send_text("\"str ing\" 'c' continue struct false identifier_long9");
    send_text("1. 2.x 7.");
    send_text("( ) { } ; , + * / - % [ ] : . =");
    send_text("x @ y");
    send_text("# define");
    send_text("!x");
    send_text("\"open");
    send_text("'open");
    send_text("#");
    send_text("<");
    send_text("abc\t1\x0b2\x0c3\r4 _Z9");
    send_text("");
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  function automatic string rand_piece();
    string parts[] = '{"int", "void", "while", "switch", "cin", "cout", "bool",
                       "double", "enum", "const", "true", "char", "if", "else",
                       "for", "case", "break", "string", "return", "intx", "foo_1",
                       "123", "4.56", "7.", "<<", ">>", "==", "!=", "<=", ">=",
                       "<", ">", "=", "\"s t\"", "'q'", "#pragma once\n", ";",
                       "(", ")", "{", "}", ",", "+", "-", "*", "/", "%", "[", "]",
                       ":", ".", " ", "\n", "\t", "Ab_Z"};
    return parts[$urandom_range(0, parts.size() - 1)];
  endfunction

  task automatic test_random_text();
    int unsigned sent;
    string s;
    sent = 0;
    while (sent < 70) begin
      s = "";
      for (int k = $urandom_range(1, 8); k > 0; k--) begin
        s = {s, rand_piece()};
        if ($urandom_range(0, 3) == 0) s = {s, " "};
      end
      // some texts get noise: any byte value
      if ($urandom_range(0, 4) == 0) s = {s, string'(byte'($urandom))};
      send_text(s);
      sent += s.len() + 1;
    end
  endtask

  task automatic test_backpressure();
    hold_len = 60;
    hold_off = 1'b1;
    stall_en = 1'b0;
    send_text("a b c d e f g h i j k l m n o p q r s t", 1'b0);
    stall_en = 1'b1;
  endtask

  initial begin
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    n_errors = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    hold_len = 0;
    stall_en = 1'b1;
    lex_reset();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random_text();
    while (token_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
